// ===== src/pcrt_pkg.sv =====
// Shared types and constants for the pedal change and repeat trigger.
`default_nettype none

package pcrt_pkg;

	localparam int TIME_W   = 32;
	localparam int PERIOD_W = 16;
	localparam int SEQ_W    = 32;
	localparam int S_DATA_W = 40;  // 3 state bits + time, padded to bytes
	localparam int M_DATA_W = 40;  // 4 state bits + sequence, padded to bytes

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(250);

	typedef struct packed {
		logic              left;
		logic              right;
		logic              button;
		logic [TIME_W-1:0] now_ms;
		logic              binding;
	} sample_t;

	typedef struct packed {
		logic              last_left;
		logic              last_right;
		logic              last_button;
		logic              last_combo;
		logic [TIME_W-1:0] left_mark;
		logic [TIME_W-1:0] right_mark;
		logic [TIME_W-1:0] combo_mark;
		logic [SEQ_W-1:0]  count;
	} trk_state_t;

	typedef struct packed {
		logic             send;
		logic             left;
		logic             right;
		logic             button;
		logic             combo;
		logic [SEQ_W-1:0] seq;
	} result_t;

endpackage

`default_nettype wire

// ===== src/pedal_change_repeat_trigger.sv =====
// Top level of the pedal change and auto-repeat report trigger.
// Usage:
//  - Slave stream (s_*) takes one sample request per cycle while s_tready is
//    high: pedal, button and time in s_tdata, the pairing flag in s_tuser.
//    A sample taken while pairing runs yields a result with send = 0 and leaves the state alone.
//  - Master stream (m_*) returns exactly one result per sample, in order.
//    m_tuser is the send flag; with send = 0 the whole m_tdata is zero.
//  - A sample passes the input register, then the result register, before
//    m_tvalid rises; a stall on m_tready can hold it in between. Throughput:
//    one sample per cycle while the receiver keeps m_tready high; the
//    decision is a single pass of compares and subtracts between those two
//    registers, and the tracking state updates in the same cycle the result
//    is registered.
//  - When the receiver stalls, the result register holds and the input
//    register still takes one more sample; s_tready drops only when both are
//    full and m_tready is low.
//  - cfg_we/cfg_wdata write the repeat period (ms); write only while idle.
//  - Reset (arst_n low): both stages empty, states released, marks and the
//    sequence counter zero, repeat period 250 ms.
`default_nettype none

module pedal_change_repeat_trigger import pcrt_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration
	input  wire logic                cfg_we,
	input  wire logic [PERIOD_W-1:0] cfg_wdata,  // repeat_period_ms
	// sample requests
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,    // [0] left_pressed, [1] right_pressed,
	                                             // [2] button_pressed, [34:3] now_ms, rest 0
	input  wire logic                s_tuser,    // [0] binding_active
	// results
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,    // [0] report_left, [1] report_right,
	                                             // [2] report_button, [3] report_combo,
	                                             // [35:4] sequence_number, rest 0
	output logic                     m_tuser     // [0] send
);

	// stage 1: registered sample
	logic       valid_s1;
	sample_t    smp_s1;
	// stage 2: registered result
	logic       valid_s2;
	result_t    res_s2;

	logic [PERIOD_W-1:0] period_q;
	trk_state_t          st_q;
	trk_state_t          st_nxt;
	result_t             res;

	logic adv_s2;   // result register loads
	logic take_s1;  // input register loads

	assign adv_s2   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s2;
	assign take_s1  = s_tvalid && s_tready;

	pcrt_decide u_decide (
		.smp    (smp_s1),
		.st     (st_q),
		.period (period_q),
		.st_nxt (st_nxt),
		.res    (res)
	);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			period_q <= cfg_wdata;
		end
	end

	// tracking state: moves only when the sample is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv_s2) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (take_s1) begin
			smp_s1.left    <= s_tdata[0];
			smp_s1.right   <= s_tdata[1];
			smp_s1.button  <= s_tdata[2];
			smp_s1.now_ms  <= s_tdata[3 +: TIME_W];
			smp_s1.binding <= s_tuser;
		end
		if (adv_s2) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.send;
	assign m_tdata  = {{(M_DATA_W-4-SEQ_W){1'b0}}, res_s2.seq,
	                   res_s2.combo, res_s2.button, res_s2.right, res_s2.left};

	// the counter steps exactly when a report is produced
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		$past(adv_s2) && $past(res.send) |-> st_q.count == $past(st_q.count) + SEQ_W'(1))
		else $error("sequence counter did not step on a report");

	// a held or pairing sample leaves the counter alone
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv_s2 && res.send) |=> $stable(st_q.count))
		else $error("sequence counter moved without a report");

	// pairing samples never report
	a_binding_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && smp_s1.binding |-> !res.send)
		else $error("report raised during pairing");

	// a non-report result carries all-zero data
	a_quiet_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("non-report result with nonzero data");

endmodule

`default_nettype wire

// ===== src/pcrt_decide.sv =====
// Report decision: change and held-repeat checks in priority order.
`default_nettype none

module pcrt_decide import pcrt_pkg::*; (
	input  sample_t             smp,
	input  trk_state_t          st,
	input  logic [PERIOD_W-1:0] period,
	output trk_state_t          st_nxt,
	output result_t             res
);

	logic              combo;
	logic              need;
	logic [TIME_W-1:0] per_ext;
	logic [TIME_W-1:0] el_c;
	logic [TIME_W-1:0] el_l;
	logic [TIME_W-1:0] el_r;

	assign combo   = smp.left & smp.right;
	assign per_ext = {{(TIME_W-PERIOD_W){1'b0}}, period};
	// elapsed times wrap mod 2^32
	assign el_c = smp.now_ms - st.combo_mark;
	assign el_l = smp.now_ms - st.left_mark;
	assign el_r = smp.now_ms - st.right_mark;

	always_comb begin
		st_nxt = st;
		res    = '0;
		need   = 1'b0;
		if (!smp.binding) begin
			// combo first
			if (combo != st.last_combo) begin
				need = 1'b1;
				if (combo) begin
					st_nxt.combo_mark = smp.now_ms;
				end
			end else if (combo && el_c >= per_ext) begin
				need = 1'b1;
				st_nxt.combo_mark = smp.now_ms;
			end
			// single pedals are muted while the combo is down
			if (!need && !combo) begin
				if (smp.left != st.last_left) begin
					need = 1'b1;
					if (smp.left) begin
						st_nxt.left_mark = smp.now_ms;
					end
				end else if (smp.left && el_l >= per_ext) begin
					need = 1'b1;
					st_nxt.left_mark = smp.now_ms;
				end
			end
			if (!need && !combo) begin
				if (smp.right != st.last_right) begin
					need = 1'b1;
					if (smp.right) begin
						st_nxt.right_mark = smp.now_ms;
					end
				end else if (smp.right && el_r >= per_ext) begin
					need = 1'b1;
					st_nxt.right_mark = smp.now_ms;
				end
			end
			// button: change only
			if (!need && smp.button != st.last_button) begin
				need = 1'b1;
			end
			if (need) begin
				res.send           = 1'b1;
				res.left           = smp.left;
				res.right          = smp.right;
				res.button         = smp.button;
				res.combo          = combo;
				res.seq            = st.count;
				st_nxt.count       = st.count + SEQ_W'(1);
				st_nxt.last_left   = smp.left;
				st_nxt.last_right  = smp.right;
				st_nxt.last_button = smp.button;
				st_nxt.last_combo  = combo;
			end
		end
	end

endmodule

`default_nettype wire
